FILE: src/utb_pkg.sv
// ----------------------------------------------------------------------------
// utb_pkg
// Types and constants shared by the text console buffer modules.
// ----------------------------------------------------------------------------
package utb_pkg;

    // request kinds
    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_SET   = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [20:0] SPACE_CP   = 21'h20;
    localparam logic [20:0] QMARK_CP   = 21'h3F;
    localparam logic [20:0] NEWLINE_CP = 21'h0A;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [4:0] column;
        logic [1:0] row;
        logic       refresh_after_clear;
        logic [6:0] read_index;
    } request_t;

    typedef struct packed {
        logic        is_refresh;
        logic [20:0] glyph;
        logic [6:0]  cursor_position;
    } result_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_END,
        OP_SET,
        OP_CLEAR,
        OP_READ
    } op_code_t;

    // value: code point (PUT), {row, column} (SET), refresh flag (CLEAR), index (READ)
    typedef struct packed {
        op_code_t    code;
        logic [20:0] value;
    } op_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_SCROLL,
        B_PUT,
        B_READ,
        B_EMIT
    } back_state_t;

endpackage

FILE: src/utb_stream_if.sv
// ----------------------------------------------------------------------------
// utb_stream_if
// Valid/ready channel carrying one typed request or result.
// ----------------------------------------------------------------------------
interface utb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/utf8_text_console_buffer.sv
// ----------------------------------------------------------------------------
// utf8_text_console_buffer
// UTF-8 text console: decodes text bytes into a scrolling COLUMNS x ROWS
// glyph store and answers refresh and glyph read requests.
//
//   channel   dir  payload     handshake
//   request   in   request_t   valid/ready, taken when both high
//   result    out  result_t    valid/ready, taken when both high
//
// A text byte or set cursor is queued and done by the store engine when it is
// popped, so a run of them goes at one per cycle while the engine is idle and
// no scroll is due. End of text shows its refresh via the queue, emit state and
// result register (behind a '?' glyph after an open 2-byte sequence); a glyph
// read goes via the queue, the read state (one registered memory read), the
// emit state and the result register, without the read state for an index
// out of range. A clear walks the store once. A glyph written past the end
// scrolls, one store entry moved per cycle over the single write port.
// After reset the store is swept to spaces; requests queue up meanwhile. A
// stalled result holds the store engine only when the next result is due; the
// decoder keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
module utf8_text_console_buffer
    import utb_pkg::*;
#(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    utb_stream_if.sink   request,
    utb_stream_if.source result
);

    logic push_valid;
    op_t  push_op;
    logic queue_full;
    logic pop_valid;
    op_t  pop_op;
    logic pop_ready;

    utb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_op    (push_op),
        .queue_full (queue_full)
    );

    utb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready)
    );

    utb_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_op    (pop_op),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

FILE: src/utb_front.sv
// ----------------------------------------------------------------------------
// utb_front
// Accepts requests, decodes UTF-8 text bytes and issues console operations.
// ----------------------------------------------------------------------------
module utb_front
    import utb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    utb_stream_if.sink   request,
    output logic         push_valid,
    output op_t          push_op,
    input  logic         queue_full
);

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  length_reg, length_next;
    logic [20:0] partial_reg, partial_next;
    logic        bad_reg, bad_next;
    logic        stopped_reg, stopped_next;
    logic        end_pend_reg, end_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            length_reg   <= '0;
            partial_reg  <= '0;
            bad_reg      <= 1'b0;
            stopped_reg  <= 1'b0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            length_reg   <= length_next;
            partial_reg  <= partial_next;
            bad_reg      <= bad_next;
            stopped_reg  <= stopped_next;
            end_pend_reg <= end_pend_next;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        cont;
        logic        stop;
        logic        bad;
        logic [20:0] joined;
        logic [1:0]  left;

        b      = request.payload.data_byte;
        cont   = (b[7:6] == 2'b10);
        joined = {partial_reg[14:0], b[5:0]};
        stop   = 1'b0;
        bad    = bad_reg | ~cont;
        left   = pending_reg - 2'd1;

        pending_next  = pending_reg;
        length_next   = length_reg;
        partial_next  = partial_reg;
        bad_next      = bad_reg;
        stopped_next  = stopped_reg;
        end_pend_next = end_pend_reg;
        push_valid    = 1'b0;
        push_op.code  = OP_PUT;
        push_op.value = '0;

        request.ready = !end_pend_reg && !queue_full;

        if (end_pend_reg)
        begin
            if (!queue_full)
            begin
                push_valid    = 1'b1;
                push_op.code  = OP_END;
                end_pend_next = 1'b0;
            end
        end
        else if (request.valid && request.ready)
        begin
            case (request.payload.kind)
                KIND_TEXT:
                begin
                    if (!stopped_reg)
                    begin
                        if (pending_reg == 2'd0)
                        begin
                            if (!b[7])
                            begin
                                if (b == 8'h00)
                                    stop = 1'b1;
                                else
                                begin
                                    push_valid    = 1'b1;
                                    push_op.value = 21'(b);
                                end
                            end
                            else if (cont)
                                stop = 1'b1;
                            else if (b[7:5] == 3'b110)
                            begin
                                length_next  = 2'd1;
                                pending_next = 2'd1;
                                partial_next = 21'(b[4:0]);
                                bad_next     = 1'b0;
                            end
                            else if (b[7:4] == 4'b1110)
                            begin
                                length_next  = 2'd2;
                                pending_next = 2'd2;
                                partial_next = 21'(b[3:0]);
                                bad_next     = 1'b0;
                            end
                            else if (b[7:3] == 5'b11110)
                            begin
                                length_next  = 2'd3;
                                pending_next = 2'd3;
                                partial_next = 21'(b[2:0]);
                                bad_next     = 1'b0;
                            end
                            else
                                stop = 1'b1;
                        end
                        else if (length_reg == 2'd1)
                        begin
                            pending_next = '0;
                            length_next  = '0;
                            partial_next = '0;
                            bad_next     = 1'b0;
                            if (!cont)
                            begin
                                push_valid    = 1'b1;
                                push_op.value = QMARK_CP;
                            end
                            else if (joined == 21'd0)
                                stop = 1'b1;
                            else
                            begin
                                push_valid    = 1'b1;
                                push_op.value = joined;
                            end
                        end
                        else
                        begin
                            bad_next     = bad;
                            partial_next = joined;
                            pending_next = left;
                            if (left == 2'd0)
                            begin
                                length_next  = '0;
                                partial_next = '0;
                                bad_next     = 1'b0;
                                if (bad || joined == 21'd0)
                                    stop = 1'b1;
                                else
                                begin
                                    push_valid    = 1'b1;
                                    push_op.value = joined;
                                end
                            end
                        end
                    end
                end
                KIND_END:
                begin
                    push_valid = 1'b1;
                    if (!stopped_reg && pending_reg != 2'd0 && length_reg == 2'd1)
                    begin
                        push_op.value = QMARK_CP;
                        end_pend_next = 1'b1;
                    end
                    else
                        push_op.code = OP_END;
                    pending_next = '0;
                    length_next  = '0;
                    partial_next = '0;
                    bad_next     = 1'b0;
                    stopped_next = 1'b0;
                end
                KIND_SET:
                begin
                    push_valid    = 1'b1;
                    push_op.code  = OP_SET;
                    push_op.value = 21'({request.payload.row, request.payload.column});
                end
                KIND_CLEAR:
                begin
                    push_valid    = 1'b1;
                    push_op.code  = OP_CLEAR;
                    push_op.value = 21'(request.payload.refresh_after_clear);
                end
                KIND_READ:
                begin
                    push_valid    = 1'b1;
                    push_op.code  = OP_READ;
                    push_op.value = 21'(request.payload.read_index);
                end
                default:
                begin
                end
            endcase

            if (stop)
            begin
                pending_next = '0;
                length_next  = '0;
                partial_next = '0;
                bad_next     = 1'b0;
                stopped_next = 1'b1;
            end
        end
    end

endmodule

FILE: src/utb_queue.sv
// ----------------------------------------------------------------------------
// utb_queue
// Short operation queue between the decoder and the store engine.
// ----------------------------------------------------------------------------
module utb_queue
    import utb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  op_t  push_op,
    output logic full,
    output logic pop_valid,
    output op_t  pop_op,
    input  logic pop_ready
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    op_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

FILE: src/utb_back.sv
// ----------------------------------------------------------------------------
// utb_back
// Glyph store engine: cursor, store sweeps, scroll, reads and result register.
// ----------------------------------------------------------------------------
module utb_back
    import utb_pkg::*;
#(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    input  op_t          pop_op,
    output logic         pop_ready,
    utb_stream_if.source result
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW        = $clog2(CELLS + 1);
    localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CUR_MAX   = (CELLS > 4 * COLUMNS + 31) ? CELLS : 4 * COLUMNS + 31;
    localparam int CUR_W     = ($clog2(CUR_MAX + 1) > 7) ? $clog2(CUR_MAX + 1) : 7;
    localparam int BASE_LAST = (ROWS - 1) * COLUMNS;

    function automatic logic [COL_W-1:0] col_of(input logic [4:0] c);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (c == 5'(i))
                r = COL_W'(i % COLUMNS);
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c);
        return (c == COL_W'(COLUMNS - 1)) ? '0 : c + 1'b1;
    endfunction

    back_state_t      state_reg, state_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [20:0]      hold_reg, hold_next;
    logic             res_refresh_reg, res_refresh_next;
    logic             clr_refresh_reg, clr_refresh_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_payload_reg, out_payload_next;

    logic [20:0]      mem [CELLS];
    logic [20:0]      rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [20:0]      mem_wd;
    logic [AW-1:0]    mem_ra;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_INIT;
            cursor_reg      <= '0;
            col_reg         <= '0;
            cnt_reg         <= '0;
            res_refresh_reg <= 1'b0;
            clr_refresh_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            col_reg         <= col_next;
            cnt_reg         <= cnt_next;
            res_refresh_reg <= res_refresh_next;
            clr_refresh_reg <= clr_refresh_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg        <= hold_next;
        out_payload_reg <= out_payload_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_comb
    begin
        logic [CW:0]      src;
        logic [CW-1:0]    dst;
        logic [CUR_W-1:0] idx;

        src = (CW + 1)'(cnt_reg) + (CW + 1)'(COLUMNS);
        dst = cnt_reg - 1'b1;
        idx = CUR_W'(pop_op.value[6:0]);

        state_next       = state_reg;
        cursor_next      = cursor_reg;
        col_next         = col_reg;
        cnt_next         = cnt_reg;
        hold_next        = hold_reg;
        res_refresh_next = res_refresh_reg;
        clr_refresh_next = clr_refresh_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_payload_next = out_payload_reg;
        pop_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = cnt_reg[AW-1:0];
        mem_wd           = SPACE_CP;
        mem_ra           = '0;

        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CELLS - 1))
                begin
                    cnt_next = '0;
                    if (state_reg == B_CLEAR && clr_refresh_reg)
                    begin
                        res_refresh_next = 1'b1;
                        hold_next        = '0;
                        state_next       = B_EMIT;
                    end
                    else
                        state_next = B_IDLE;
                end
            end
            B_SCROLL:
            begin
                if (src < (CW + 1)'(CELLS))
                    mem_ra = src[AW-1:0];
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = dst[AW-1:0];
                    mem_wd = (dst < CW'(BASE_LAST)) ? rd_data_reg : SPACE_CP;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = B_PUT;
                end
            end
            B_PUT:
            begin
                mem_we      = 1'b1;
                mem_wa      = AW'(BASE_LAST);
                mem_wd      = hold_reg;
                cursor_next = CUR_W'(BASE_LAST + 1);
                col_next    = col_inc('0);
                state_next  = B_IDLE;
            end
            B_READ:
            begin
                hold_next        = rd_data_reg;
                res_refresh_next = 1'b0;
                state_next       = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next                   = 1'b1;
                    out_payload_next.is_refresh      = res_refresh_reg;
                    out_payload_next.glyph           = hold_reg;
                    out_payload_next.cursor_position = cursor_reg[6:0];
                    state_next                       = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    pop_ready = 1'b1;
                    case (pop_op.code)
                        OP_PUT:
                        begin
                            if (pop_op.value == NEWLINE_CP)
                            begin
                                if (col_reg != '0)
                                    cursor_next = cursor_reg + CUR_W'(COLUMNS)
                                                  - CUR_W'(col_reg);
                                col_next = '0;
                            end
                            else if (cursor_reg >= CUR_W'(CELLS))
                            begin
                                hold_next  = pop_op.value;
                                cnt_next   = '0;
                                state_next = B_SCROLL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_wa      = cursor_reg[AW-1:0];
                                mem_wd      = pop_op.value;
                                cursor_next = cursor_reg + 1'b1;
                                col_next    = col_inc(col_reg);
                            end
                        end
                        OP_END:
                        begin
                            res_refresh_next = 1'b1;
                            hold_next        = '0;
                            state_next       = B_EMIT;
                        end
                        OP_SET:
                        begin
                            cursor_next = CUR_W'(pop_op.value[6:5]) * CUR_W'(COLUMNS)
                                          + CUR_W'(pop_op.value[4:0]);
                            col_next    = col_of(pop_op.value[4:0]);
                        end
                        OP_CLEAR:
                        begin
                            cursor_next      = '0;
                            col_next         = '0;
                            clr_refresh_next = pop_op.value[0];
                            cnt_next         = '0;
                            state_next       = B_CLEAR;
                        end
                        OP_READ:
                        begin
                            res_refresh_next = 1'b0;
                            if (idx < CUR_W'(CELLS))
                            begin
                                mem_ra     = idx[AW-1:0];
                                state_next = B_READ;
                            end
                            else
                            begin
                                hold_next  = '0;
                                state_next = B_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

FILE: src/utb_checker.sv
// ----------------------------------------------------------------------------
// utb_checker
// Port-level checks on the result channel of the text console buffer.
// ----------------------------------------------------------------------------
module utb_checker
    import utb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_payload
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result changed while stalled");

    // refresh results carry no glyph
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.is_refresh |-> res_payload.glyph == 21'd0)
        else $error("refresh result with nonzero glyph");

    // nothing is presented right out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind utf8_text_console_buffer utb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_payload (result.payload)
);

FILE: bench/tb_utf8_text_console_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_text_console_buffer
// Self-checking bench for the UTF-8 text console buffer. A scoreboard keeps
// its own copy of the decoder, cursor and glyph store, predicts the refresh
// and glyph read results of every accepted request, and compares them field
// by field with what the block returns. A short directed run is followed by
// random requests, mostly well-formed text, under three idle patterns.
// ----------------------------------------------------------------------------
module tb_utf8_text_console_buffer;
    import utb_pkg::*;

    localparam int COLUMNS    = 20;
    localparam int ROWS       = 4;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int QUIET_MAX  = 3000;
    localparam int TAIL_WAIT  = 200;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_SIZE = 170;

    // kinds the block ignores
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    class glyph_scoreboard;
        logic [20:0] cells [CELLS];
        int unsigned cursor;
        int unsigned pending;
        int unsigned seq_len;
        logic [20:0] partial;
        bit          seq_bad;
        bit          stopped;
        result_t     answers_due[$];
        int          errors;
        int          shown;

        function new();
            blank();
            cursor  = 0;
            clear_decoder();
            stopped = 1'b0;
            errors  = 0;
            shown   = 0;
        endfunction

        function void blank();
            foreach (cells[i])
                cells[i] = SPACE_CP;
        endfunction

        function void clear_decoder();
            pending = 0;
            seq_len = 0;
            partial = '0;
            seq_bad = 1'b0;
        endfunction

        function void stop_write();
            clear_decoder();
            stopped = 1'b1;
        endfunction

        function void put_glyph(logic [20:0] cp);
            if (cp == NEWLINE_CP)
            begin
                cursor = COLUMNS * ((cursor + COLUMNS - 1) / COLUMNS);
                return;
            end
            if (cursor >= CELLS)
            begin
                for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    cells[i] = cells[i + COLUMNS];
                for (int i = 0; i < COLUMNS; i++)
                    cells[(ROWS - 1) * COLUMNS + i] = SPACE_CP;
                cursor = (ROWS - 1) * COLUMNS;
            end
            cells[cursor] = cp;
            cursor++;
        endfunction

        function void emit(logic [20:0] cp);
            if (cp == '0)
                stop_write();
            else
                put_glyph(cp);
        endfunction

        function void push_answer(logic refresh, logic [20:0] glyph);
            result_t a;
            a.is_refresh      = refresh;
            a.glyph           = glyph;
            a.cursor_position = 7'(cursor);
            answers_due.push_back(a);
        endfunction

        function void note_request(request_t r);
            logic [7:0]  b;
            logic [20:0] cp;
            bit          cont;
            bit          was_bad;
            b    = r.data_byte;
            cont = (b[7:6] == 2'b10);
            case (r.kind)
                KIND_TEXT:
                begin
                    if (stopped)
                        return;
                    if (pending == 0)
                    begin
                        if (!b[7])
                            emit(21'(b));
                        else if (cont)
                            stop_write();
                        else if (b[7:5] == 3'b110)
                        begin
                            seq_len = 1; pending = 1; partial = 21'(b[4:0]); seq_bad = 1'b0;
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            seq_len = 2; pending = 2; partial = 21'(b[3:0]); seq_bad = 1'b0;
                        end
                        else if (b[7:3] == 5'b11110)
                        begin
                            seq_len = 3; pending = 3; partial = 21'(b[2:0]); seq_bad = 1'b0;
                        end
                        else
                            stop_write();
                    end
                    else if (seq_len == 1)
                    begin
                        cp = {partial[14:0], b[5:0]};
                        clear_decoder();
                        if (!cont)
                            put_glyph(QMARK_CP);
                        else
                            emit(cp);
                    end
                    else
                    begin
                        if (!cont)
                            seq_bad = 1'b1;
                        partial = {partial[14:0], b[5:0]};
                        pending--;
                        if (pending == 0)
                        begin
                            cp      = partial;
                            was_bad = seq_bad;
                            clear_decoder();
                            if (was_bad)
                                stop_write();
                            else
                                emit(cp);
                        end
                    end
                end
                KIND_END:
                begin
                    if (!stopped && pending != 0 && seq_len == 1)
                        put_glyph(QMARK_CP);
                    clear_decoder();
                    stopped = 1'b0;
                    push_answer(1'b1, '0);
                end
                KIND_SET:
                    cursor = r.row * COLUMNS + r.column;
                KIND_CLEAR:
                begin
                    blank();
                    cursor = 0;
                    if (r.refresh_after_clear)
                        push_answer(1'b1, '0);
                end
                KIND_READ:
                    push_answer(1'b0, (r.read_index < CELLS) ? cells[r.read_index] : '0);
                default: ;
            endcase
        endfunction

        function void complain(string msg);
            errors++;
            if (shown < 10)
            begin
                shown++;
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        function void check_answer(result_t got);
            result_t want;
            if (answers_due.size() == 0)
            begin
                complain($sformatf("result with none due: refresh %0b glyph %h cursor %0d",
                                   got.is_refresh, got.glyph, got.cursor_position));
                return;
            end
            want = answers_due.pop_front();
            if (got.is_refresh !== want.is_refresh)
                complain($sformatf("is_refresh expected %0b got %0b",
                                   want.is_refresh, got.is_refresh));
            if (got.glyph !== want.glyph)
                complain($sformatf("glyph expected %h got %h", want.glyph, got.glyph));
            if (got.cursor_position !== want.cursor_position)
                complain($sformatf("cursor_position expected %0d got %0d",
                                   want.cursor_position, got.cursor_position));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    utb_stream_if #(.T(request_t)) req_if ();
    utb_stream_if #(.T(result_t))  res_if ();

    utf8_text_console_buffer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    glyph_scoreboard sb;
    int send_idle_pct;
    int take_idle_pct;
    int hold_left;

    wire req_fire = req_if.valid && req_if.ready;
    wire res_fire = res_if.valid && res_if.ready;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_fire)
                sb.check_answer(res_if.payload);
            if (req_fire)
                sb.note_request(req_if.payload);
        end
    end

    // result side: random stalls, plus one long hold-off in the last random phase
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_if.ready = 1'b0;
                hold_left--;
            end
            else
                res_if.ready = ($urandom_range(99) >= take_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if (!rst_n || req_fire || res_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic request_t any_request(logic [2:0] k);
        request_t r;
        r      = request_t'(26'($urandom));
        r.kind = k;
        return r;
    endfunction

    function automatic request_t text_req(logic [7:0] b);
        request_t r;
        r           = any_request(KIND_TEXT);
        r.data_byte = b;
        return r;
    endfunction

    function automatic request_t set_req(logic [4:0] c, logic [1:0] rw);
        request_t r;
        r        = any_request(KIND_SET);
        r.column = c;
        r.row    = rw;
        return r;
    endfunction

    function automatic request_t read_req(logic [6:0] idx);
        request_t r;
        r            = any_request(KIND_READ);
        r.read_index = idx;
        return r;
    endfunction

    function automatic request_t clear_req(logic refresh);
        request_t r;
        r                     = any_request(KIND_CLEAR);
        r.refresh_after_clear = refresh;
        return r;
    endfunction

    task automatic push_request(input request_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.payload = r;
        req_if.valid   = 1'b1;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
    endtask

    task automatic drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (sb.answers_due.size() != 0)
            @(posedge clk);
    endtask

    // UTF-8 encoding of cp in n bytes, overlong forms allowed
    function automatic void encode(logic [20:0] cp, int n, ref logic [7:0] seq[$]);
        seq.delete();
        case (n)
            1: seq.push_back({1'b0, cp[6:0]});
            2:
            begin
                seq.push_back({3'b110, cp[10:6]});
                seq.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                seq.push_back({4'b1110, cp[15:12]});
                seq.push_back({2'b10, cp[11:6]});
                seq.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                seq.push_back({5'b11110, cp[20:18]});
                seq.push_back({2'b10, cp[17:12]});
                seq.push_back({2'b10, cp[11:6]});
                seq.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    task automatic random_items(input int count);
        int          sent;
        int          pick;
        int          n;
        int          pos;
        logic [20:0] cp;
        logic [7:0]  seq[$];
        request_t    r;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                n  = $urandom_range(1, 4);
                cp = 21'($urandom);
                case (n)
                    1: cp = 21'(cp[6:0]);
                    2: cp = 21'(cp[10:0]);
                    3: cp = 21'(cp[15:0]);
                    default: ;
                endcase
                if ($urandom_range(7) == 0)
                begin
                    n  = 1;
                    cp = NEWLINE_CP;
                end
                else if (cp == '0 && $urandom_range(3) != 0)
                    cp = 21'h41;
                encode(cp, n, seq);
                foreach (seq[i])
                    push_request(text_req(seq[i]));
                sent += seq.size();
            end
            else if (pick < 64)
            begin
                // broken sequence: one byte replaced, or cut short
                encode(21'($urandom), $urandom_range(2, 4), seq);
                pos = $urandom_range(1, seq.size() - 1);
                if ($urandom_range(1))
                    seq[pos] = 8'($urandom);
                else
                    seq = seq[0:pos - 1];
                foreach (seq[i])
                    push_request(text_req(seq[i]));
                sent += seq.size();
            end
            else
            begin
                if (pick < 69)
                    r = text_req(8'($urandom));
                else if (pick < 80)
                    r = read_req(($urandom_range(9) == 0) ? 7'($urandom_range(80, 127))
                                                          : 7'($urandom_range(0, 79)));
                else if (pick < 85)
                    r = set_req(($urandom_range(4) == 0) ? 5'($urandom_range(20, 31))
                                                         : 5'($urandom_range(0, 19)),
                                2'($urandom));
                else if (pick < 87)
                    r = clear_req(1'($urandom));
                else if (pick < 98)
                    r = any_request(KIND_END);
                else
                    r = any_request(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
                push_request(r);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb             = new();
        send_idle_pct  = 18;
        take_idle_pct  = 81;
        hold_left      = 0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        push_request(read_req(7'd127));
        push_request(text_req(8'h41));
        push_request(text_req(8'hC3));
        push_request(read_req(7'd0));      // command inside a sequence
        push_request(text_req(8'hA9));
        push_request(text_req(8'hF0));
        push_request(text_req(8'h9F));
        push_request(text_req(8'h98));
        push_request(text_req(8'h80));
        push_request(text_req(8'hE2));     // bad continuation, 3-byte
        push_request(text_req(8'h41));
        push_request(text_req(8'h82));
        push_request(text_req(8'h42));     // dropped
        push_request(any_request(KIND_END));
        push_request(text_req(8'hC3));     // open 2-byte at end of text
        push_request(any_request(KIND_END));
        push_request(text_req(8'hC0));     // overlong zero
        push_request(text_req(8'h80));
        push_request(any_request(KIND_END));
        push_request(set_req(5'd31, 2'd3));
        push_request(text_req(NEWLINE_CP[7:0]));
        push_request(text_req(8'h7E));     // scrolls
        push_request(read_req(7'd60));
        push_request(clear_req(1'b1));
        push_request(clear_req(1'b0));
        push_request(any_request(KIND_SPARE_LAST));
        drain();

        random_items(PHASE_SIZE);
        drain();

        send_idle_pct = 81;
        take_idle_pct = 18;
        random_items(PHASE_SIZE);
        drain();

        send_idle_pct = 0;
        take_idle_pct = 0;
        hold_left     = LONG_HOLD;
        random_items(PHASE_SIZE);
        drain();

        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
src/utb_pkg.sv
src/utb_stream_if.sv
src/utb_front.sv
src/utb_queue.sv
src/utb_back.sv
src/utf8_text_console_buffer.sv
src/utb_checker.sv
bench/tb_utf8_text_console_buffer.sv
